### hdl/cvr_pkg.sv
// shared constants, types and tables for the camera vector rotator
// no dependencies; used by the interfaces, the micro-rotation stage and the top level
package cvr_pkg;

    localparam int SCREEN_WIDTH = 1024;
    localparam int SW_LOG       = $clog2(SCREEN_WIDTH);
    localparam int MX_W         = 10;
    localparam int FACING_W     = 2;
    localparam int TR_W         = 14;
    localparam int VEC_W        = 16;
    localparam int FRAC_W       = 14;
    localparam int D_W          = SW_LOG + 1;
    localparam int MXC_W        = 14;
    localparam int ANG_SHIFT    = 12 - SW_LOG;
    localparam int ANG_W        = 27;
    localparam int ACC_W        = 32;
    localparam int GAIN_W       = 30;
    localparam int PROD_W       = ACC_W + GAIN_W + 1;
    localparam int RND_W        = PROD_W + 1;
    localparam int RND_SHIFT    = 44;
    localparam int STEPS        = 24;
    localparam int CNT_W        = $clog2(STEPS);
    localparam int NUM_COMP     = 4;
    localparam int COMP_W       = $clog2(NUM_COMP);
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 27'sd26353589;
    localparam logic [GAIN_W-1:0]       GAIN_Q30    = 30'd652032874;

    localparam logic [23:0] ATAN_Q24 [STEPS] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    localparam logic [FACING_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [FACING_W-1:0] FACE_SOUTH = 2'd1;
    localparam logic [FACING_W-1:0] FACE_EAST  = 2'd2;
    localparam logic [FACING_W-1:0] FACE_WEST  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y   = 3'd4;

    localparam logic [COMP_W-1:0] VI_DIR_X   = 2'd0;
    localparam logic [COMP_W-1:0] VI_DIR_Y   = 2'd1;
    localparam logic [COMP_W-1:0] VI_PLANE_X = 2'd2;
    localparam logic [COMP_W-1:0] VI_PLANE_Y = 2'd3;

    localparam logic [TR_W-1:0]         RST_TURN_RATE = 14'd410;
    localparam logic signed [VEC_W-1:0] RST_DIR_X     = 16'sd0;
    localparam logic signed [VEC_W-1:0] RST_DIR_Y     = -16'sd16384;
    localparam logic signed [VEC_W-1:0] RST_PLANE_X   = 16'sd10813;
    localparam logic signed [VEC_W-1:0] RST_PLANE_Y   = 16'sd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANGLE,
        S_PREROT,
        S_ITER,
        S_GAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] shift;
        logic             sub;
    } t_step_ctl;

endpackage

### hdl/cvr_in_if.sv
// input channel: pointer position and view facing with valid/ready
// depends on cvr_pkg
interface cvr_in_if;
    import cvr_pkg::*;

    logic                valid;
    logic                ready;
    logic [MX_W-1:0]     mouse_x;
    logic [FACING_W-1:0] facing;

    modport source (output valid, output mouse_x, output facing, input ready);
    modport sink   (input valid, input mouse_x, input facing, output ready);
endinterface

### hdl/cvr_out_if.sv
// output channel: rotated direction and plane vectors with valid/ready
// depends on cvr_pkg
interface cvr_out_if;
    import cvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] new_dir_x;
    logic signed [VEC_W-1:0] new_dir_y;
    logic signed [VEC_W-1:0] new_plane_x;
    logic signed [VEC_W-1:0] new_plane_y;

    modport source (output valid, output new_dir_x, output new_dir_y,
                    output new_plane_x, output new_plane_y, input ready);
    modport sink   (input valid, input new_dir_x, input new_dir_y,
                    input new_plane_x, input new_plane_y, output ready);
endinterface

### hdl/cvr_step.sv
// one cordic micro-rotation of an x/y pair: shift by the step index, add or subtract
// depends on cvr_pkg
module cvr_step (
    input  cvr_pkg::t_step_ctl          i_ctl,
    input  logic signed [cvr_pkg::ACC_W-1:0] i_x,
    input  logic signed [cvr_pkg::ACC_W-1:0] i_y,
    output logic signed [cvr_pkg::ACC_W-1:0] o_x,
    output logic signed [cvr_pkg::ACC_W-1:0] o_y
);
    import cvr_pkg::*;

    logic signed [ACC_W-1:0] w_dx;
    logic signed [ACC_W-1:0] w_dy;

    assign w_dx = i_y >>> i_ctl.shift;
    assign w_dy = i_x >>> i_ctl.shift;

    always_comb begin
        if (i_ctl.sub) begin
            o_x = i_x + w_dx;
            o_y = i_y - w_dy;
        end else begin
            o_x = i_x - w_dx;
            o_y = i_y + w_dy;
        end
    end
endmodule

### hdl/camera_vector_rotator.sv
// top level of the camera vector rotator: config registers, sequencer, angle and gain datapath
// depends on cvr_pkg, cvr_in_if, cvr_out_if and cvr_step
//
// Holds the camera direction and plane vectors (signed Q2.14) and rotates both by one angle
// per pointer word, the angle being (SCREEN_WIDTH/2 - mouse_x) * turn_rate / SCREEN_WIDTH
// radians, negated when facing south or west. One word is worked at a time: after acceptance it goes
// through the angle multiply, the quarter-turn pre-rotation, the 24 passes through the shift-add
// micro-rotation stages (one per vector), the one gain multiplier and the load of the output
// register, which waits while an earlier result has still not been taken. The input
// is ready again as soon as the result is moved to the output register, even while that result
// waits to be taken. Writing any start register reloads both vectors; turn_rate writes leave
// them alone. SCREEN_WIDTH must be a power of two.
module camera_vector_rotator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cvr_in_if.sink                        i_in,
    cvr_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [cvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cvr_pkg::VEC_W-1:0]     i_cfg_data
);
    import cvr_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;
    logic                    r_out_valid;
    logic                    n_out_valid;

    logic [TR_W-1:0]         r_turn;
    logic signed [VEC_W-1:0] r_start [NUM_COMP];
    logic signed [VEC_W-1:0] r_vec   [NUM_COMP];
    logic signed [VEC_W-1:0] r_res   [NUM_COMP];

    logic signed [D_W-1:0]    r_d;
    logic signed [ANG_W-1:0]  r_ang;
    logic signed [ACC_W-1:0]  r_wx [2];
    logic signed [ACC_W-1:0]  r_wy [2];
    logic signed [PROD_W-1:0] r_prod;

    logic                      w_accept;
    logic                      w_load_out;
    logic [MXC_W-1:0]          w_mx;
    logic signed [MXC_W-1:0]   w_dfull;
    logic signed [MXC_W-1:0]   w_dsig;
    logic signed [TR_W:0]      w_tr;
    logic signed [D_W+TR_W:0]  w_angp;
    logic signed [ANG_W-1:0]   w_atan;
    logic signed [ACC_W-1:0]   w_px [2];
    logic signed [ACC_W-1:0]   w_py [2];
    logic signed [ACC_W-1:0]   w_sx [2];
    logic signed [ACC_W-1:0]   w_sy [2];
    t_step_ctl                 w_ctl;
    logic signed [ACC_W-1:0]   w_gsel;
    logic signed [GAIN_W:0]    w_gain;
    logic signed [RND_W-1:0]   w_rsum;
    logic signed [RND_W-1:0]   w_rsh;
    logic signed [VEC_W-1:0]   w_round;
    logic [CNT_W-1:0]          w_rcnt;
    logic [COMP_W-1:0]         w_ridx;
    logic [COMP_W-1:0]         w_gidx;

    // handshake
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign o_out.valid       = r_out_valid;
    assign o_out.new_dir_x   = r_res[VI_DIR_X];
    assign o_out.new_dir_y   = r_res[VI_DIR_Y];
    assign o_out.new_plane_x = r_res[VI_PLANE_X];
    assign o_out.new_plane_y = r_res[VI_PLANE_Y];

    // signed pointer offset, clamped to the screen and negated when facing south or west
    always_comb begin
        w_mx = MXC_W'(i_in.mouse_x);
        if (w_mx > MXC_W'(SCREEN_WIDTH - 1)) begin
            w_mx = MXC_W'(SCREEN_WIDTH - 1);
        end
        w_dfull = $signed(MXC_W'(SCREEN_WIDTH / 2)) - $signed(w_mx);
        if (i_in.facing == FACE_SOUTH || i_in.facing == FACE_WEST) begin
            w_dsig = -w_dfull;
        end else begin
            w_dsig = w_dfull;
        end
    end

    assign w_tr   = $signed({1'b0, r_turn});
    assign w_angp = r_d * w_tr;
    assign w_atan = $signed({{(ANG_W - 24){1'b0}}, ATAN_Q24[r_cnt]});

    // quarter-turn pre-rotation operands
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_px[k] = ACC_W'(r_vec[2 * k]) <<< FRAC_W;
            w_py[k] = ACC_W'(r_vec[2 * k + 1]) <<< FRAC_W;
        end
    end

    // shared micro-rotation stage, one per vector, same direction
    assign w_ctl.shift = r_cnt;
    assign w_ctl.sub   = r_ang[ANG_W-1];

    cvr_step u_step_dir (
        .i_ctl (w_ctl),
        .i_x   (r_wx[0]),
        .i_y   (r_wy[0]),
        .o_x   (w_sx[0]),
        .o_y   (w_sy[0])
    );

    cvr_step u_step_plane (
        .i_ctl (w_ctl),
        .i_x   (r_wx[1]),
        .i_y   (r_wy[1]),
        .o_x   (w_sx[1]),
        .o_y   (w_sy[1])
    );

    // gain compensation: multiply one component per cycle, round the previous one
    assign w_gidx = r_cnt[COMP_W-1:0];
    assign w_gain = $signed({1'b0, GAIN_Q30});

    always_comb begin
        case (w_gidx)
            VI_DIR_X:   w_gsel = r_wx[0];
            VI_DIR_Y:   w_gsel = r_wy[0];
            VI_PLANE_X: w_gsel = r_wx[1];
            VI_PLANE_Y: w_gsel = r_wy[1];
            default:    w_gsel = r_wx[0];
        endcase
    end

    assign w_rcnt = r_cnt - CNT_W'(1);
    assign w_ridx = w_rcnt[COMP_W-1:0];
    assign w_rsum = RND_W'(r_prod) + (RND_W'(1) <<< (RND_SHIFT - 1));
    assign w_rsh  = w_rsum >>> RND_SHIFT;

    always_comb begin
        if (w_rsh > RND_W'(32767)) begin
            w_round = 16'sd32767;
        end else if (w_rsh < -RND_W'(32768)) begin
            w_round = -16'sd32768;
        end else begin
            w_round = w_rsh[VEC_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_state = S_PREROT;
            end
            S_PREROT: begin
                n_state = S_ITER;
                n_cnt   = '0;
            end
            S_ITER: begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = S_GAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_GAIN: begin
                if (r_cnt == CNT_W'(NUM_COMP)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // config registers and vector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn                <= RST_TURN_RATE;
            r_start[VI_DIR_X]     <= RST_DIR_X;
            r_start[VI_DIR_Y]     <= RST_DIR_Y;
            r_start[VI_PLANE_X]   <= RST_PLANE_X;
            r_start[VI_PLANE_Y]   <= RST_PLANE_Y;
            r_vec[VI_DIR_X]       <= RST_DIR_X;
            r_vec[VI_DIR_Y]       <= RST_DIR_Y;
            r_vec[VI_PLANE_X]     <= RST_PLANE_X;
            r_vec[VI_PLANE_Y]     <= RST_PLANE_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TURN_RATE: begin
                    r_turn <= i_cfg_data[TR_W-1:0];
                end
                CFG_DIR_X: begin
                    r_start[VI_DIR_X] <= i_cfg_data;
                    r_vec[VI_DIR_X]   <= i_cfg_data;
                    r_vec[VI_DIR_Y]   <= r_start[VI_DIR_Y];
                    r_vec[VI_PLANE_X] <= r_start[VI_PLANE_X];
                    r_vec[VI_PLANE_Y] <= r_start[VI_PLANE_Y];
                end
                CFG_DIR_Y: begin
                    r_start[VI_DIR_Y] <= i_cfg_data;
                    r_vec[VI_DIR_X]   <= r_start[VI_DIR_X];
                    r_vec[VI_DIR_Y]   <= i_cfg_data;
                    r_vec[VI_PLANE_X] <= r_start[VI_PLANE_X];
                    r_vec[VI_PLANE_Y] <= r_start[VI_PLANE_Y];
                end
                CFG_PLANE_X: begin
                    r_start[VI_PLANE_X] <= i_cfg_data;
                    r_vec[VI_DIR_X]     <= r_start[VI_DIR_X];
                    r_vec[VI_DIR_Y]     <= r_start[VI_DIR_Y];
                    r_vec[VI_PLANE_X]   <= i_cfg_data;
                    r_vec[VI_PLANE_Y]   <= r_start[VI_PLANE_Y];
                end
                CFG_PLANE_Y: begin
                    r_start[VI_PLANE_Y] <= i_cfg_data;
                    r_vec[VI_DIR_X]     <= r_start[VI_DIR_X];
                    r_vec[VI_DIR_Y]     <= r_start[VI_DIR_Y];
                    r_vec[VI_PLANE_X]   <= r_start[VI_PLANE_X];
                    r_vec[VI_PLANE_Y]   <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_GAIN && r_cnt != '0) begin
            r_vec[w_ridx] <= w_round;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_d <= D_W'(w_dsig);
                end
            end
            S_ANGLE: begin
                r_ang <= ANG_W'(w_angp) <<< ANG_SHIFT;
            end
            S_PREROT: begin
                if (r_ang > HALF_PI_Q24) begin
                    r_wx[0] <= -w_py[0];
                    r_wy[0] <= w_px[0];
                    r_wx[1] <= -w_py[1];
                    r_wy[1] <= w_px[1];
                    r_ang   <= r_ang - HALF_PI_Q24;
                end else if (r_ang < -HALF_PI_Q24) begin
                    r_wx[0] <= w_py[0];
                    r_wy[0] <= -w_px[0];
                    r_wx[1] <= w_py[1];
                    r_wy[1] <= -w_px[1];
                    r_ang   <= r_ang + HALF_PI_Q24;
                end else begin
                    r_wx[0] <= w_px[0];
                    r_wy[0] <= w_py[0];
                    r_wx[1] <= w_px[1];
                    r_wy[1] <= w_py[1];
                end
            end
            S_ITER: begin
                r_wx[0] <= w_sx[0];
                r_wy[0] <= w_sy[0];
                r_wx[1] <= w_sx[1];
                r_wy[1] <= w_sy[1];
                if (w_ctl.sub) begin
                    r_ang <= r_ang + w_atan;
                end else begin
                    r_ang <= r_ang - w_atan;
                end
            end
            S_GAIN: begin
                r_prod <= w_gsel * w_gain;
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_res <= r_vec;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

### verif/tb_camera_vector_rotator.sv
`timescale 1ns / 1ps
// testbench for camera_vector_rotator: pointer words and register writes in, rotated views checked
// against a fixed-point cordic predictor kept in the bench
// depends on cvr_pkg, cvr_in_if, cvr_out_if and the camera_vector_rotator rtl
module tb_camera_vector_rotator;
    import cvr_pkg::*;

    localparam int     CLK_HALF_NS  = 2;
    localparam int     RESET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 64;
    localparam int     TIMEOUT_NS   = 10_000_000;
    localparam int     CHUNKS       = 6;
    localparam int     CHUNK_WORDS  = 78;
    localparam int     ROT_STEPS    = 24;
    localparam longint QUARTER_TURN = 26353589;
    localparam longint GAIN_COMP    = 652032874;
    localparam longint ARCTAN [ROT_STEPS] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };
    localparam logic [TR_W-1:0]         INIT_RATE    = 14'd410;
    localparam logic signed [VEC_W-1:0] INIT_DIR_X   = 16'sd0;
    localparam logic signed [VEC_W-1:0] INIT_DIR_Y   = -16'sd16384;
    localparam logic signed [VEC_W-1:0] INIT_PLANE_X = 16'sd10813;
    localparam logic signed [VEC_W-1:0] INIT_PLANE_Y = 16'sd0;
    localparam logic [TR_W-1:0]         RATE_PI      = 14'd12867;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } t_pair;

    typedef struct packed {
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] plane_x;
        logic signed [VEC_W-1:0] plane_y;
    } t_view;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VEC_W-1:0]     cfg_data;

    cvr_in_if  in_if ();
    cvr_out_if out_if ();

    camera_vector_rotator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [TR_W-1:0]         turn_rate;
    logic signed [VEC_W-1:0] start_dir_x, start_dir_y, start_plane_x, start_plane_y;
    t_pair                   cam_dir, cam_plane;
    t_view                   pending_views [$];
    bit                      failed;
    int                      send_idle_pct;
    int                      recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [VEC_W-1:0] round_sat(longint acc);
        longint r;
        r = (acc * GAIN_COMP + (longint'(1) <<< 43)) >>> 44;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[VEC_W-1:0];
    endfunction

    function automatic t_pair rotate_pair(t_pair v, longint ang);
        logic signed [VEC_W-1:0] sx, sy;
        longint                  x, y, t, dx, dy;
        int                      i;
        t_pair                   r;
        sx = v.x;
        sy = v.y;
        x = sx;
        y = sy;
        x = x * 16384;
        y = y * 16384;
        if (ang > QUARTER_TURN) begin
            t = x; x = -y; y = t; ang = ang - QUARTER_TURN;
        end else if (ang < -QUARTER_TURN) begin
            t = x; x = y; y = -t; ang = ang + QUARTER_TURN;
        end
        for (i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x = x - dx; y = y + dy; ang = ang - ARCTAN[i];
            end else begin
                x = x + dx; y = y - dy; ang = ang + ARCTAN[i];
            end
        end
        r.x = round_sat(x);
        r.y = round_sat(y);
        return r;
    endfunction

    function automatic void rotate_camera(logic [MX_W-1:0] mx, logic [FACING_W-1:0] face);
        longint col, ang;
        col = longint'(mx);
        if (col > SCREEN_WIDTH - 1)
            col = SCREEN_WIDTH - 1;
        ang = (longint'(SCREEN_WIDTH / 2) - col) * longint'(turn_rate) * 4096
              / longint'(SCREEN_WIDTH);
        if (face == FACE_SOUTH || face == FACE_WEST)
            ang = -ang;
        cam_dir   = rotate_pair(cam_dir, ang);
        cam_plane = rotate_pair(cam_plane, ang);
        pending_views.push_back('{cam_dir.x, cam_dir.y, cam_plane.x, cam_plane.y});
    endfunction

    function automatic void reload_vectors();
        cam_dir   = '{start_dir_x, start_dir_y};
        cam_plane = '{start_plane_x, start_plane_y};
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] data);
        case (idx)
            CFG_TURN_RATE: turn_rate = data[TR_W-1:0];
            CFG_DIR_X: begin
                start_dir_x = data; reload_vectors();
            end
            CFG_DIR_Y: begin
                start_dir_y = data; reload_vectors();
            end
            CFG_PLANE_X: begin
                start_plane_x = data; reload_vectors();
            end
            CFG_PLANE_Y: begin
                start_plane_y = data; reload_vectors();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic signed [VEC_W-1:0] want,
                                        logic signed [VEC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic void check_view();
        t_view want;
        if (pending_views.size() == 0) begin
            $error("rotated view word with none expected");
            failed = 1'b1;
        end else begin
            want = pending_views.pop_front();
            check_field("new_dir_x", want.dir_x, out_if.new_dir_x);
            check_field("new_dir_y", want.dir_y, out_if.new_dir_y);
            check_field("new_plane_x", want.plane_x, out_if.new_plane_x);
            check_field("new_plane_y", want.plane_y, out_if.new_plane_y);
        end
    endfunction

    // result side: check on the sampled handshake, then pick the next ready
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                check_view();
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_pointer(logic [MX_W-1:0] mx, logic [FACING_W-1:0] face);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.mouse_x <= mx;
        in_if.facing  <= face;
        do @(posedge i_clk); while (!in_if.ready);
        rotate_camera(mx, face);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        apply_register(idx, data);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [VEC_W-1:0] pick_coord();
        int v;
        case ($urandom_range(4))
            0: return VEC_W'($urandom);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: begin
                v = int'($urandom_range(32768)) - 16384;
                return v[VEC_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] pick_rate();
        case ($urandom_range(5))
            0: return '0;
            1: return VEC_W'(RATE_PI);
            2: return VEC_W'($urandom);
            default: return VEC_W'($urandom_range(RATE_PI));
        endcase
    endfunction

    task automatic random_setup();
        int k;
        write_reg(CFG_TURN_RATE, pick_rate());
        if ($urandom_range(3) != 0) begin
            if ($urandom_range(3) != 0) write_reg(CFG_DIR_X, pick_coord());
            if ($urandom_range(3) != 0) write_reg(CFG_DIR_Y, pick_coord());
            if ($urandom_range(3) != 0) write_reg(CFG_PLANE_X, pick_coord());
            if ($urandom_range(3) != 0) write_reg(CFG_PLANE_Y, pick_coord());
        end
        if ($urandom_range(4) == 0) begin
            k = $urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_PLANE_Y) + 1);
            write_reg(k[CFG_IDX_W-1:0], VEC_W'($urandom));
        end
        end_writes();
    endtask

    task automatic test_default_view();
        send_pointer('0, FACE_NORTH);
        send_pointer('0, FACE_SOUTH);
        send_pointer('0, FACE_EAST);
        send_pointer('0, FACE_WEST);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_NORTH);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_SOUTH);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_EAST);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_WEST);
        send_pointer(MX_W'(SCREEN_WIDTH / 2), FACE_NORTH);
        drain_results();
    endtask

    task automatic test_extreme_setup();
        int k;
        // rate write with the upper data bits set, saturating start vectors
        write_reg(CFG_TURN_RATE, '1);
        write_reg(CFG_DIR_X, 16'h7FFF);
        write_reg(CFG_DIR_Y, 16'h7FFF);
        write_reg(CFG_PLANE_X, 16'h8000);
        write_reg(CFG_PLANE_Y, 16'h8000);
        end_writes();
        send_pointer('0, FACE_NORTH);
        send_pointer('0, FACE_SOUTH);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_EAST);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_WEST);
        send_pointer(MX_W'(SCREEN_WIDTH / 2), FACE_NORTH);
        drain_results();

        write_reg(CFG_TURN_RATE, VEC_W'(RATE_PI));
        write_reg(CFG_DIR_X, 16'h8000);
        write_reg(CFG_DIR_Y, 16'h8000);
        write_reg(CFG_PLANE_X, 16'h7FFF);
        write_reg(CFG_PLANE_Y, 16'h7FFF);
        end_writes();
        send_pointer('0, FACE_EAST);
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_SOUTH);
        drain_results();

        write_reg(CFG_TURN_RATE, '0);
        end_writes();
        send_pointer(MX_W'(SCREEN_WIDTH - 1), FACE_WEST);
        send_pointer('0, FACE_NORTH);
        drain_results();

        // unused register indexes must leave everything alone
        write_reg(CFG_TURN_RATE, VEC_W'(INIT_RATE));
        for (k = int'(CFG_PLANE_Y) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], VEC_W'($urandom));
        end_writes();
        send_pointer(MX_W'(SCREEN_WIDTH / 4), FACE_EAST);
        drain_results();
    endtask

    task automatic test_random_pointer(int send_pct, int recv_pct);
        int c, w;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (c = 0; c < CHUNKS; c++) begin
            random_setup();
            for (w = 0; w < CHUNK_WORDS; w++)
                send_pointer(MX_W'($urandom_range(SCREEN_WIDTH - 1)),
                             FACING_W'($urandom_range(3)));
            drain_results();
        end
    endtask

    initial begin
        failed        = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 60;
        turn_rate     = INIT_RATE;
        start_dir_x   = INIT_DIR_X;
        start_dir_y   = INIT_DIR_Y;
        start_plane_x = INIT_PLANE_X;
        start_plane_y = INIT_PLANE_Y;
        reload_vectors();
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.mouse_x <= '0;
        in_if.facing  <= FACE_NORTH;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_TURN_RATE;
        cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_view();
        test_extreme_setup();
        test_random_pointer(12, 60);
        test_random_pointer(60, 12);
        test_random_pointer(0, 0);

        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hdl/cvr_pkg.sv
hdl/cvr_in_if.sv
hdl/cvr_out_if.sv
hdl/cvr_step.sv
hdl/camera_vector_rotator.sv
verif/tb_camera_vector_rotator.sv
